// ===== rtl/core/vafd_pkg.sv =====
// Shared types, constants and byte fetch helper for the vertex attribute decoder.
package vafd_pkg;

	localparam int unsigned InWidth  = 112;
	localparam int unsigned OutWidth = 128;

	typedef enum logic [1:0] {
		KIND_GENERIC = 2'd0,
		KIND_NORMAL  = 2'd1,
		KIND_COLOR   = 2'd2,
		KIND_OTHER   = 2'd3
	} kind_t;

	// generic formats
	localparam logic [2:0] FMT_U8  = 3'd0;
	localparam logic [2:0] FMT_S8  = 3'd1;
	localparam logic [2:0] FMT_U16 = 3'd2;
	localparam logic [2:0] FMT_S16 = 3'd3;
	localparam logic [2:0] FMT_F32 = 3'd4;
	// color formats
	localparam logic [2:0] COL_RGB565 = 3'd0;
	localparam logic [2:0] COL_RGB8   = 3'd1;
	localparam logic [2:0] COL_RGBX8  = 3'd2;
	localparam logic [2:0] COL_RGBA4  = 3'd3;
	localparam logic [2:0] COL_RGBA6  = 3'd4;
	localparam logic [2:0] COL_RGBA8  = 3'd5;

	localparam logic [31:0] FLOAT_ONE  = 32'h3f80_0000;
	localparam logic [31:0] FLOAT_ZERO = 32'h0000_0000;

	// float mantissas (hidden bit included) and exponent offsets of the scale factors
	localparam logic [23:0] MANT_BYTE = 24'h808081; // 0x1.010102p-8
	localparam logic [4:0]  BIAS_BYTE = 5'd31;
	localparam logic [23:0] MANT_D31  = 24'h842108; // 1/31
	localparam logic [4:0]  BIAS_D31  = 5'd28;
	localparam logic [23:0] MANT_D63  = 24'h820821; // 1/63
	localparam logic [4:0]  BIAS_D63  = 5'd29;
	localparam logic [23:0] MANT_D15  = 24'h888889; // 1/15
	localparam logic [4:0]  BIAS_D15  = 5'd27;

	// one component on its way to a float: value = round24(x) * 2^-nbias
	typedef struct packed {
		logic        byp;
		logic [31:0] byp_bits;
		logic        sign;
		logic        is_col;
		logic [31:0] mag;
		logic [7:0]  mul8;
		logic [23:0] mant;
		logic [4:0]  nbias;
	} lane_t;

	function automatic logic [31:0] fetch_val(input logic [95:0] raw, input logic [3:0] at,
			input logic [2:0] wid, input logic little);
		logic [31:0] v;
		logic [3:0]  idx;
		v = '0;
		for (int i = 0; i < 4; i++) begin
			idx = at + 4'(i);
			if (3'(i) < wid) begin
				if (little)
					v = v | (32'(raw[8*idx +: 8]) << (8*i));
				else
					v = {v[23:0], raw[8*idx +: 8]};
			end
		end
		return v;
	endfunction

endpackage

// ===== rtl/core/vertex_attribute_format_decode_core.sv =====
// Vertex attribute format decoder: field unpack, then four float conversion lanes.
// Pipeline stages from the input beat to the output beat: unpack, scale multiply,
// leading-one search, round and pack, each stage one register.
// Throughput: one attribute per cycle; a stall on the output freezes all stages.
// Reset (arst_n low, asynchronous) clears the stage valid bits; data regs are not reset.
module vertex_attribute_format_decode_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// attr_kind[1:0], present[2], format_type[5:3], component_count[9:6],
	// frac_bits[14:10], little_endian[15], raw_low[79:16], raw_high[111:80]
	input  logic [vafd_pkg::InWidth-1:0]    s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// comp_x[31:0], comp_y[63:32], comp_z[95:64], comp_w[127:96]
	output logic [vafd_pkg::OutWidth-1:0]   m_tdata
);
	import vafd_pkg::*;

	logic        en;
	logic        valid_s1, valid_s2, valid_s3, valid_s4;
	kind_t       kind;
	logic        present, little;
	logic [2:0]  fmt, wid;
	logic [3:0]  count;
	logic [4:0]  frac;
	logic [95:0] raw;
	lane_t       lane_c [4];
	lane_t       lane_s1 [4];
	logic [31:0] res_s4 [4];
	logic [31:0] v;
	logic [32:0] n;
	logic [7:0]  fld;

	assign en       = !valid_s4 || m_tready;
	assign s_tready = en;
	assign m_tvalid = valid_s4;

	assign kind    = kind_t'(s_tdata[1:0]);
	assign present = s_tdata[2];
	assign fmt     = s_tdata[5:3];
	assign count   = s_tdata[9:6];
	assign frac    = s_tdata[14:10];
	assign little  = s_tdata[15];
	assign raw     = s_tdata[111:16];

	always_comb begin
		wid = (fmt < FMT_U16) ? 3'd1 : (fmt < FMT_F32) ? 3'd2 : 3'd4;
		v   = '0;
		n   = '0;
		fld = '0;
		for (int k = 0; k < 4; k++) begin
			lane_c[k] = '{byp: 1'b1, byp_bits: FLOAT_ZERO, sign: 1'b0, is_col: 1'b0,
				mag: '0, mul8: '0, mant: '0, nbias: '0};
		end
		if (!present) begin
			if (kind == KIND_COLOR) begin
				for (int k = 0; k < 4; k++) lane_c[k].byp_bits = FLOAT_ONE;
			end else if (kind == KIND_NORMAL) begin
				lane_c[0].byp_bits = FLOAT_ONE;
			end
		end else if (kind == KIND_COLOR) begin
			if (fmt == COL_RGB8 || fmt == COL_RGBX8 || fmt == COL_RGBA8) begin
				for (int k = 0; k < 4; k++) begin
					lane_c[k].byp    = (k == 3) && (fmt != COL_RGBA8);
					lane_c[k].byp_bits = FLOAT_ONE;
					lane_c[k].is_col = 1'b1;
					lane_c[k].mul8   = raw[8*k +: 8];
					lane_c[k].mant   = MANT_BYTE;
					lane_c[k].nbias  = BIAS_BYTE;
				end
			end else begin
				v = fetch_val(raw, 4'd0, (fmt == COL_RGBA6) ? 3'd3 : 3'd2, little);
				for (int k = 0; k < 4; k++) begin
					lane_c[k].byp    = 1'b0;
					lane_c[k].is_col = 1'b1;
					if (fmt == COL_RGB565) begin
						unique case (k)
							0:       fld = 8'(v[15:11]);
							1:       fld = 8'(v[10:5]);
							2:       fld = 8'(v[4:0]);
							default: fld = '0;
						endcase
						lane_c[k].byp      = (k == 3);
						lane_c[k].byp_bits = FLOAT_ONE;
						lane_c[k].mant     = (k == 1) ? MANT_D63 : MANT_D31;
						lane_c[k].nbias    = (k == 1) ? BIAS_D63 : BIAS_D31;
					end else if (fmt == COL_RGBA4) begin
						fld = 8'((v >> (12 - 4*k)) & 32'hf);
						lane_c[k].mant  = MANT_D15;
						lane_c[k].nbias = BIAS_D15;
					end else begin
						fld = 8'((v >> (18 - 6*k)) & 32'h3f);
						lane_c[k].mant  = MANT_D63;
						lane_c[k].nbias = BIAS_D63;
					end
					lane_c[k].mul8 = fld;
				end
			end
		end else begin
			for (int k = 0; k < 3; k++) begin
				v = fetch_val(raw, 4'(k * wid), wid, little);
				if (fmt == FMT_U8 || fmt == FMT_U16)
					n = {1'b0, v};
				else if (fmt == FMT_S8)
					n = 33'(signed'(v[7:0]));
				else if (fmt == FMT_S16)
					n = 33'(signed'(v[15:0]));
				else
					n = 33'(signed'(v));
				if ((k == 0) || (k == 1 && count > 4'd1) || (k == 2 && count > 4'd2)) begin
					if (fmt == FMT_F32) begin
						lane_c[k].byp_bits = v;
					end else begin
						lane_c[k].byp   = 1'b0;
						lane_c[k].sign  = n[32];
						lane_c[k].mag   = n[32] ? (32'd0 - n[31:0]) : n[31:0];
						lane_c[k].nbias = frac;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) lane_s1 <= lane_c;
	end

	for (genvar g = 0; g < 4; g++) begin : g_lane
		vafd_lane u_lane (
			.clk     (clk),
			.en      (en),
			.lane_s1 (lane_s1[g]),
			.res_s4  (res_s4[g])
		);
	end

	assign m_tdata = {res_s4[3], res_s4[2], res_s4[1], res_s4[0]};

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(valid_s1) && $stable(valid_s2) && $stable(valid_s3)))
		else $error("pipeline moved during stall");
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> valid_s1)
		else $error("accepted beat lost at stage 1");
	a_s1_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && en) |=> valid_s2)
		else $error("beat lost between stage 1 and 2");
	a_s3_out: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && en) |=> m_tvalid)
		else $error("beat lost before output");

endmodule

// ===== rtl/core/vafd_lane.sv =====
// One component lane: scale multiply, leading-one search, round and pack to float.
module vafd_lane (
	input  logic                 clk,
	input  logic                 en,
	input  vafd_pkg::lane_t      lane_s1,
	output logic [31:0]          res_s4
);
	import vafd_pkg::*;

	logic        byp_s2, sign_s2;
	logic [31:0] bits_s2, x_s2;
	logic [4:0]  nb_s2;

	logic        byp_s3, sign_s3, zero_s3;
	logic [31:0] bits_s3, x_s3;
	logic [4:0]  nb_s3, p_s3;

	logic [4:0]  p_c;
	logic        zero_c;
	logic [31:0] res_c;
	logic [4:0]  shamt;
	logic [31:0] shx, rem, half;
	logic [24:0] m25;
	logic        rnd;
	logic [8:0]  expo;

	always_ff @(posedge clk) begin
		if (en) begin
			byp_s2  <= lane_s1.byp;
			bits_s2 <= lane_s1.byp_bits;
			sign_s2 <= lane_s1.sign;
			nb_s2   <= lane_s1.nbias;
			x_s2    <= lane_s1.is_col ? 32'(lane_s1.mul8 * lane_s1.mant) : lane_s1.mag;
		end
	end

	always_comb begin
		p_c    = '0;
		zero_c = (x_s2 == '0);
		for (int i = 0; i < 32; i++)
			if (x_s2[i]) p_c = 5'(i);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			byp_s3  <= byp_s2;
			bits_s3 <= bits_s2;
			sign_s3 <= sign_s2;
			nb_s3   <= nb_s2;
			x_s3    <= x_s2;
			p_s3    <= p_c;
			zero_s3 <= zero_c;
		end
	end

	always_comb begin
		shamt = '0;
		shx   = '0;
		rem   = '0;
		half  = '0;
		rnd   = 1'b0;
		if (p_s3 > 5'd23) begin
			shamt = p_s3 - 5'd23;
			shx   = x_s3 >> shamt;
			rem   = x_s3 & ((32'd1 << shamt) - 32'd1);
			half  = 32'd1 << (shamt - 5'd1);
			rnd   = (rem > half) || ((rem == half) && shx[0]);
		end else begin
			shx = x_s3 << (5'd23 - p_s3);
		end
		m25  = {1'b0, shx[23:0]} + 25'(rnd);
		// round up past all ones bumps the exponent, mantissa goes to zero
		expo = 9'(p_s3) + 9'd127 - 9'(nb_s3) + 9'(m25[24]);
		if (byp_s3)
			res_c = bits_s3;
		else if (zero_s3)
			res_c = FLOAT_ZERO;
		else
			res_c = {sign_s3, expo[7:0], m25[24] ? 23'd0 : m25[22:0]};
	end

	always_ff @(posedge clk) begin
		if (en) res_s4 <= res_c;
	end

endmodule
